// File: hw/rtl/prt_pkg.sv
`default_nettype none
package prt_pkg;
    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 48;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = 5;
    localparam int ID_W      = 64;
    localparam int TAG_W     = 16;
    localparam int WORD_W    = 64;
    localparam int ERR_W     = 16;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_COMPLETE = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_EXPIRE   = 3'd3,
        CMD_FLUSH    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LIMIT    = 2'd1,
        ST_DUP      = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_FLUSHED  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [TAG_W-1:0]     tag;
        logic [ID_W-1:0]      id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

// File: hw/rtl/prt_ram.sv
`default_nettype none
module prt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic                 re,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/pending_request_tracker.sv
// pending_request_tracker: table of outstanding requests keyed by a 64-bit id.
// Commands enter on the s_ beat channel (cmd in s_tuser), results leave on the
// m_ channel (out_kind in m_tuser, last in m_tlast). cfg_we/cfg_wdata set the
// pending limit (zero acts as one, above 16 acts as 16); write only when idle.
// One command is worked at a time. Every command first scans all 16 table
// slots through the entry memory, one read a cycle; the memory has a
// registered read port, and each result beat is registered after the scan.
// Add, complete, remove and unused codes give one result. Expire and fail-all
// clear matching slots during the scan, then read each freed slot back from
// memory one freed entry at a time, giving a result for each, and close with
// a result that carries the freed count and has m_tlast high.
// The result register holds a beat while m_tready is low; the block waits
// for it to drain before writing the next result. s_tready is high only
// between commands. Reset clears all valid bits, the count and the outputs
// and sets the limit to 16; entry contents need no clearing.
`default_nettype none
module pending_request_tracker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [4:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // req_key, call_tag, deadline_time, now_time, result_word, error_code
    input  wire logic [255:0] s_tdata,
    // cmd
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, out_id, out_tag, out_word, occupancy, freed_count, zero pad
    output logic [159:0]      m_tdata,
    // out_kind
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import prt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_FREAD,
        S_FOUT,
        S_CLOSE
    } state_t;

    state_t                state_reg;
    logic [2:0]            cmd_reg;
    logic [ID_W-1:0]       id_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [TIME_BITS-1:0]  dl_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [ERR_W-1:0]      err_reg;
    logic [DEPTH-1:0]      valid_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [4:0]            maxp_reg;
    logic [IDX_W:0]        idx_reg;
    logic                  pend_reg;
    logic [IDX_W-1:0]      ridx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [TAG_W-1:0]      hit_tag_reg;
    logic [DEPTH-1:0]      mask_reg;
    logic [CNT_W-1:0]      freed_reg;
    logic                  m_tvalid_reg;
    logic [159:0]          m_tdata_reg;
    logic [1:0]            m_tuser_reg;
    logic                  m_tlast_reg;

    logic                  out_load;
    logic [159:0]          m_tdata_next;
    logic [1:0]            m_tuser_next;
    logic                  m_tlast_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    entry_t                rd_entry;
    logic [ENTRY_W-1:0]    rd_bits;
    entry_t                wr_entry;

    logic                  out_free;
    logic [CNT_W-1:0]      limit;
    logic                  any_free;
    logic [IDX_W-1:0]      free_slot;
    logic [IDX_W-1:0]      mask_slot;
    logic                  sweep_cmd;
    logic                  hit;

    assign rd_entry = entry_t'(rd_bits);
    assign wr_entry = '{deadline: dl_reg, tag: tag_reg, id: id_reg};
    assign out_free = !m_tvalid_reg || m_tready;
    assign sweep_cmd = (cmd_reg == CMD_EXPIRE) || (cmd_reg == CMD_FLUSH);

    always_comb
    begin
        if (maxp_reg == '0)
            limit = CNT_W'(1);
        else if (maxp_reg > CNT_W'(DEPTH))
            limit = CNT_W'(DEPTH);
        else
            limit = maxp_reg;
    end

    // lowest free slot and lowest slot left to deliver
    always_comb
    begin
        any_free  = 1'b0;
        free_slot = '0;
        mask_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free  = 1'b1;
                free_slot = IDX_W'(i);
            end
            if (mask_reg[i])
                mask_slot = IDX_W'(i);
        end
    end

    always_comb
    begin
        hit = 1'b0;
        if (pend_reg && valid_reg[ridx_reg])
        begin
            if (sweep_cmd)
                hit = (cmd_reg == CMD_FLUSH) || (rd_entry.deadline <= now_reg);
            else
                hit = (rd_entry.id == id_reg);
        end
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = idx_reg[IDX_W-1:0];
        ram_we    = 1'b0;
        if (state_reg == S_SCAN && idx_reg != (IDX_W+1)'(DEPTH))
            ram_re = 1'b1;
        if (state_reg == S_FREAD && mask_reg != '0)
        begin
            ram_re    = 1'b1;
            ram_raddr = mask_slot;
        end
        if (state_reg == S_RESOLVE && out_free && cmd_reg == CMD_ADD
            && count_reg < limit && !found_reg && any_free)
            ram_we = 1'b1;
    end

    // next result beat
    always_comb
    begin
        out_load              = 1'b0;
        m_tdata_next          = '0;
        m_tuser_next          = KIND_NONE;
        m_tlast_next          = 1'b1;
        m_tdata_next[150:146] = count_reg;
        unique case (state_reg)
            S_RESOLVE:
            begin
                out_load = out_free;
                priority case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (count_reg >= limit || (!found_reg && !any_free))
                            m_tdata_next[1:0] = ST_LIMIT;
                        else if (found_reg)
                            m_tdata_next[1:0] = ST_DUP;
                        else
                            m_tdata_next[150:146] = count_reg + 1'b1;
                    end
                    CMD_COMPLETE, CMD_REMOVE:
                    begin
                        if (!found_reg)
                            m_tdata_next[1:0] = ST_NOTFOUND;
                        else
                        begin
                            m_tdata_next[150:146] = count_reg - 1'b1;
                            if (cmd_reg == CMD_COMPLETE)
                            begin
                                m_tuser_next         = KIND_COMPLETE;
                                m_tdata_next[65:2]   = id_reg;
                                m_tdata_next[81:66]  = hit_tag_reg;
                                m_tdata_next[145:82] = word_reg;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FOUT:
            begin
                out_load             = out_free;
                m_tlast_next         = 1'b0;
                m_tuser_next         = (cmd_reg == CMD_EXPIRE) ? KIND_EXPIRED
                                                               : KIND_FLUSHED;
                m_tdata_next[65:2]   = rd_entry.id;
                m_tdata_next[81:66]  = rd_entry.tag;
                m_tdata_next[145:82] = WORD_W'(err_reg);
            end
            S_CLOSE:
            begin
                out_load              = out_free;
                m_tdata_next[155:151] = freed_reg;
            end
            default:
            begin
            end
        endcase
    end

    prt_ram #(
        .W(ENTRY_W),
        .D(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(free_slot),
        .wdata(ENTRY_W'(wr_entry)),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rd_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            id_reg       <= '0;
            tag_reg      <= '0;
            dl_reg       <= '0;
            now_reg      <= '0;
            word_reg     <= '0;
            err_reg      <= '0;
            valid_reg    <= '0;
            count_reg    <= '0;
            maxp_reg     <= 5'd16;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            ridx_reg     <= '0;
            found_reg    <= 1'b0;
            slot_reg     <= '0;
            hit_tag_reg  <= '0;
            mask_reg     <= '0;
            freed_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= '0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                maxp_reg <= cfg_wdata;

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= m_tdata_next;
                m_tuser_reg  <= m_tuser_next;
                m_tlast_reg  <= m_tlast_next;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= s_tuser;
                        id_reg    <= s_tdata[63:0];
                        tag_reg   <= s_tdata[79:64];
                        dl_reg    <= s_tdata[127:80];
                        now_reg   <= s_tdata[175:128];
                        word_reg  <= s_tdata[239:176];
                        err_reg   <= s_tdata[255:240];
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        found_reg <= 1'b0;
                        mask_reg  <= '0;
                        freed_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pend_reg <= ram_re;
                    ridx_reg <= idx_reg[IDX_W-1:0];
                    if (ram_re)
                        idx_reg <= idx_reg + 1'b1;
                    if (hit)
                    begin
                        if (sweep_cmd)
                        begin
                            valid_reg[ridx_reg] <= 1'b0;
                            mask_reg[ridx_reg]  <= 1'b1;
                            count_reg           <= count_reg - 1'b1;
                            freed_reg           <= freed_reg + 1'b1;
                        end
                        else if (!found_reg)
                        begin
                            found_reg   <= 1'b1;
                            slot_reg    <= ridx_reg;
                            hit_tag_reg <= rd_entry.tag;
                        end
                    end
                    if (!ram_re && !pend_reg)
                        state_reg <= sweep_cmd ? S_FREAD : S_RESOLVE;
                end
                S_RESOLVE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (ram_we)
                        begin
                            valid_reg[free_slot] <= 1'b1;
                            count_reg            <= count_reg + 1'b1;
                        end
                        else if ((cmd_reg == CMD_COMPLETE || cmd_reg == CMD_REMOVE)
                                 && found_reg)
                        begin
                            valid_reg[slot_reg] <= 1'b0;
                            count_reg           <= count_reg - 1'b1;
                        end
                    end
                end
                S_FREAD:
                begin
                    if (mask_reg == '0)
                        state_reg <= S_CLOSE;
                    else
                    begin
                        mask_reg[mask_slot] <= 1'b0;
                        state_reg <= S_FOUT;
                    end
                end
                S_FOUT:
                begin
                    if (out_free)
                        state_reg <= S_FREAD;
                end
                S_CLOSE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import prt_pkg::*;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] rid;
        logic [15:0] tag;
        logic [47:0] dl;
        logic [47:0] now;
        logic [63:0] word;
        logic [15:0] err;
    } req_t;

    typedef struct {
        status_t     status;
        kind_t       kind;
        logic [63:0] id;
        logic [15:0] tag;
        logic [63:0] word;
        logic [4:0]  occ;
        logic [4:0]  freed;
        logic        last;
    } res_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [4:0]    cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [255:0]  s_tdata;
    logic [2:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [159:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;

    pending_request_tracker dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // predicted table
    logic        tbl_valid [DEPTH];
    logic [63:0] tbl_id [DEPTH];
    logic [15:0] tbl_tag [DEPTH];
    logic [47:0] tbl_dl [DEPTH];
    int          tbl_count;
    logic [4:0]  limit_reg;

    req_t cmd_queue[$];
    res_t expected_results[$];
    int   errors;
    int   sent;
    bit   idle_free;      // no random idling while set
    bit   hold_sink;
    bit   sender_pause;
    int   hold_cycles;
    int   rx_seen;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic res_t mk_res(status_t st, kind_t k, logic [63:0] id,
                                    logic [15:0] tg, logic [63:0] w,
                                    logic [4:0] fr, logic lst);
        res_t r;
        r.status = st;
        r.kind = k;
        r.id = id;
        r.tag = tg;
        r.word = w;
        r.occ = 5'(tbl_count);
        r.freed = fr;
        r.last = lst;
        return r;
    endfunction

    function automatic int find_entry(logic [63:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    // updates the predicted table and queues the results of one command
    function automatic void track_command(req_t c);
        int lim;
        int slot;
        int freed_list[$];
        lim = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : limit_reg);
        case (c.cmd)
            CMD_ADD:
            begin
                if (tbl_count >= lim)
                    expected_results.push_back(mk_res(ST_LIMIT, KIND_NONE, 0, 0, 0, 0, 1));
                else if (find_entry(c.rid) >= 0)
                    expected_results.push_back(mk_res(ST_DUP, KIND_NONE, 0, 0, 0, 0, 1));
                else
                begin
                    slot = 0;
                    while (slot < DEPTH && tbl_valid[slot])
                        slot++;
                    if (slot < DEPTH)
                    begin
                        tbl_valid[slot] = 1'b1;
                        tbl_id[slot] = c.rid;
                        tbl_tag[slot] = c.tag;
                        tbl_dl[slot] = c.dl;
                        tbl_count++;
                        expected_results.push_back(mk_res(ST_OK, KIND_NONE, 0, 0, 0, 0, 1));
                    end
                    else
                        expected_results.push_back(mk_res(ST_LIMIT, KIND_NONE, 0, 0, 0, 0, 1));
                end
            end
            CMD_COMPLETE, CMD_REMOVE:
            begin
                slot = find_entry(c.rid);
                if (slot < 0)
                    expected_results.push_back(mk_res(ST_NOTFOUND, KIND_NONE, 0, 0, 0, 0, 1));
                else
                begin
                    tbl_valid[slot] = 1'b0;
                    tbl_count--;
                    if (c.cmd == CMD_COMPLETE)
                        expected_results.push_back(mk_res(ST_OK, KIND_COMPLETE, tbl_id[slot],
                                                          tbl_tag[slot], c.word, 0, 1));
                    else
                        expected_results.push_back(mk_res(ST_OK, KIND_NONE, 0, 0, 0, 0, 1));
                end
            end
            CMD_EXPIRE, CMD_FLUSH:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] && (c.cmd == CMD_FLUSH || tbl_dl[i] <= c.now))
                    begin
                        tbl_valid[i] = 1'b0;
                        tbl_count--;
                        freed_list.push_back(i);
                    end
                // occupancy is the value after the whole sweep
                foreach (freed_list[j])
                    expected_results.push_back(mk_res(ST_OK,
                        c.cmd == CMD_EXPIRE ? KIND_EXPIRED : KIND_FLUSHED,
                        tbl_id[freed_list[j]], tbl_tag[freed_list[j]],
                        64'(c.err), 0, 0));
                expected_results.push_back(mk_res(ST_OK, KIND_NONE, 0, 0, 0,
                                                  5'(freed_list.size()), 1));
            end
            default:
                expected_results.push_back(mk_res(ST_OK, KIND_NONE, 0, 0, 0, 0, 1));
        endcase
    endfunction

    function automatic req_t rand_req();
        req_t c;
        c.cmd = 3'($urandom_range(0, 7));
        c.rid = {$urandom(), $urandom()};
        c.tag = 16'($urandom());
        c.dl = {16'($urandom()), 32'($urandom())};
        c.now = {16'($urandom()), 32'($urandom())};
        c.word = {$urandom(), $urandom()};
        c.err = 16'($urandom());
        return c;
    endfunction

    // small id pool so completes, removes and duplicates actually hit
    function automatic req_t pool_req(int add_bias);
        req_t c;
        int r;
        c = rand_req();
        c.rid = 64'($urandom_range(0, 23)) ^ 64'hA5A5_0000_0000_0000;
        c.dl = 48'($urandom_range(0, 1000));
        c.now = 48'($urandom_range(0, 1000));
        r = $urandom_range(0, 99);
        if (r < add_bias)
            c.cmd = CMD_ADD;
        else if (r < add_bias + 20)
            c.cmd = CMD_COMPLETE;
        else if (r < add_bias + 32)
            c.cmd = CMD_REMOVE;
        else if (r < 94)
            c.cmd = CMD_EXPIRE;
        else if (r < 97)
            c.cmd = CMD_FLUSH;
        else
            c.cmd = 3'($urandom_range(5, 7));
        return c;
    endfunction

    function automatic req_t directed(logic [2:0] cm, logic [63:0] id, logic [47:0] dl,
                                      logic [47:0] now);
        req_t c;
        c = rand_req();
        c.cmd = cm;
        c.rid = id;
        c.dl = dl;
        c.now = now;
        return c;
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = v;
        @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_command(cmd_queue.pop_front());
                sent <= sent + 1;
            end
            if ((s_tvalid && !s_tready) ||
                (!(s_tvalid && s_tready) && s_tvalid))
                ; // hold the offered beat
            else if (cmd_queue.size() != 0 && !sender_pause &&
                     (idle_free || $urandom_range(0, 99) >= 10))
            begin
                s_tvalid <= 1'b1;
                s_tuser <= cmd_queue[0].cmd;
                s_tdata <= {cmd_queue[0].err, cmd_queue[0].word, cmd_queue[0].now,
                            cmd_queue[0].dl, cmd_queue[0].tag, cmd_queue[0].rid};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // sink backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_sink && hold_cycles < 400)
        begin
            hold_cycles <= hold_cycles + 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= idle_free || ($urandom_range(0, 99) >= 10);
    end

    // monitor
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_seen <= rx_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat kind=%0d", m_tuser);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tdata[1:0] !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tuser !== e.kind)
                begin
                    $error("out_kind expected %0d actual %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[65:2] !== e.id)
                begin
                    $error("out_id expected %h actual %h", e.id, m_tdata[65:2]);
                    errors++;
                end
                if (m_tdata[81:66] !== e.tag)
                begin
                    $error("out_tag expected %h actual %h", e.tag, m_tdata[81:66]);
                    errors++;
                end
                if (m_tdata[145:82] !== e.word)
                begin
                    $error("out_word expected %h actual %h", e.word, m_tdata[145:82]);
                    errors++;
                end
                if (m_tdata[150:146] !== e.occ)
                begin
                    $error("occupancy expected %0d actual %0d", e.occ, m_tdata[150:146]);
                    errors++;
                end
                if (m_tdata[155:151] !== e.freed)
                begin
                    $error("freed_count expected %0d actual %0d", e.freed,
                           m_tdata[155:151]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [4:0] limits[6];
        errors = 0;
        sent = 0;
        rx_seen = 0;
        idle_free = 1'b0;
        hold_sink = 1'b0;
        sender_pause = 1'b0;
        limit_reg = 5'd16;
        tbl_count = 0;
        foreach (tbl_valid[i])
            tbl_valid[i] = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, duplicates, misses, limit
        write_limit(5'd2);
        cmd_queue.push_back(directed(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0));
        cmd_queue.push_back(directed(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 48'd5, 0));
        cmd_queue.push_back(directed(CMD_ADD, 64'd0, 48'd0, 0));
        cmd_queue.push_back(directed(CMD_ADD, 64'd7, 48'd1, 0));
        cmd_queue.push_back(directed(CMD_EXPIRE, 0, 0, 48'd0));
        cmd_queue.push_back(directed(CMD_EXPIRE, 0, 0, 48'd0));
        cmd_queue.push_back(directed(CMD_COMPLETE, 64'd0, 0, 0));
        cmd_queue.push_back(directed(CMD_REMOVE, 64'd1234, 0, 0));
        cmd_queue.push_back(directed(CMD_ADD, 64'd9, 48'd100, 0));
        cmd_queue.push_back(directed(CMD_EXPIRE, 0, 0, 48'hFFFF_FFFF_FFFE));
        cmd_queue.push_back(directed(CMD_EXPIRE, 0, 0, 48'hFFFF_FFFF_FFFF));
        cmd_queue.push_back(directed(CMD_ADD, 64'd3, 48'd1, 0));
        cmd_queue.push_back(directed(CMD_REMOVE, 64'd3, 0, 0));
        cmd_queue.push_back(directed(CMD_REMOVE, 64'd3, 0, 0));
        cmd_queue.push_back(directed(CMD_FLUSH, 0, 0, 0));
        cmd_queue.push_back(directed(3'd5, 0, 0, 0));
        cmd_queue.push_back(directed(3'd6, 0, 0, 0));
        cmd_queue.push_back(directed(3'd7, 0, 0, 0));
        wait_drained();

        // zero limit acts as one
        write_limit(5'd0);
        cmd_queue.push_back(directed(CMD_ADD, 64'd1, 48'd2, 0));
        cmd_queue.push_back(directed(CMD_ADD, 64'd2, 48'd2, 0));
        cmd_queue.push_back(directed(CMD_FLUSH, 0, 0, 0));
        wait_drained();

        // fill the whole table with limit saturating above capacity
        write_limit(5'd31);
        for (int i = 0; i < 17; i++)
            cmd_queue.push_back(directed(CMD_ADD, {$urandom(), $urandom()},
                                         48'($urandom_range(0, 99)), 0));
        // sink holds off so the result side backs up into the input
        idle_free = 1'b1;
        hold_sink = 1'b1;
        cmd_queue.push_back(directed(CMD_FLUSH, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            cmd_queue.push_back(directed(CMD_ADD, 64'(i), 48'($urandom_range(0, 99)), 0));
        cmd_queue.push_back(directed(CMD_EXPIRE, 0, 0, 48'd50));
        wait_drained();
        hold_sink = 1'b0;
        idle_free = 1'b0;

        // random phases at different limits
        limits = '{5'd16, 5'd1, 5'd4, 5'd17, 5'd9, 5'd16};
        foreach (limits[p])
        begin
            write_limit(limits[p]);
            if (p == 2)
                idle_free = 1'b1;
            for (int i = 0; i < 80; i++)
            begin
                if (i % 20 == 19)
                    cmd_queue.push_back(rand_req());
                else
                    cmd_queue.push_back(pool_req(p == 5 ? 60 : 40));
                if (i == 40)
                begin
                    // sender waits for every result before going on
                    while (cmd_queue.size() != 0 || s_tvalid)
                        @(posedge clk);
                    sender_pause = 1'b1;
                    while (expected_results.size() != 0)
                        @(posedge clk);
                    sender_pause = 1'b0;
                end
            end
            wait_drained();
            idle_free = 1'b0;
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
